// File: rtl/dxt1_pkg.sv
// Shared types, constants and helper functions of the DXT1 block decoder.
// Depends on nothing; every other file of the decoder uses it, apart from dxt1_checker.
package dxt1_pkg;

   localparam int CHAN_W = 8;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_VALID_COLUMNS = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_VALID_ROWS = 4'd1;

   localparam logic [1:0] IDX_TRANSPARENT = 2'd3;
   localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hff;
   localparam logic [CHAN_W-1:0] ALPHA_CLEAR = 8'h00;

   // Channel 0 is the low field, 1 the middle field, 2 the high field.
   typedef logic [2:0][CHAN_W-1:0] color_type;

   typedef struct packed {
      color_type [3:0] pal;
      logic four_colour;
      logic [3:0][7:0] row_indices;
      logic [1:0] cols_m1;
      logic [1:0] rows_m1;
   } block_type;

   // Maps a written extent to its last position; zero acts as one, above four as four.
   function automatic logic [1:0] extent_last(input logic [CSR_DATA_W-1:0] value);
      logic [1:0] result;
      if (value == 3'd0) begin
         result = 2'd0;
      end else if (value > 3'd4) begin
         result = 2'd3;
      end else begin
         result = 2'(value - 3'd1);
      end
      return result;
   endfunction

   // Floor of x / 3 for x below 768, as a multiply by a scaled reciprocal.
   function automatic logic [CHAN_W-1:0] div3(input logic [9:0] x);
      logic [20:0] prod;
      prod = {11'd0, x} * 21'd683;
      return prod[18:11];
   endfunction

endpackage

// File: rtl/dxt1_if.sv
// Channel interfaces of the DXT1 block decoder: blocks in, pixels out, register writes.
// Depends on dxt1_pkg for the register port widths.
interface dxt1_req_if;
   logic valid;
   logic ready;
   logic [15:0] endpoint_zero;
   logic [15:0] endpoint_one;
   logic [7:0] row_zero_indices;
   logic [7:0] row_one_indices;
   logic [7:0] row_two_indices;
   logic [7:0] row_three_indices;

   modport source (
      output valid, endpoint_zero, endpoint_one, row_zero_indices, row_one_indices,
             row_two_indices, row_three_indices,
      input ready
   );
   modport sink (
      input valid, endpoint_zero, endpoint_one, row_zero_indices, row_one_indices,
            row_two_indices, row_three_indices,
      output ready
   );
endinterface

interface dxt1_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] chan_low;
   logic [7:0] chan_mid;
   logic [7:0] chan_high;
   logic [7:0] alpha;
   logic last_pixel;

   modport source (
      output valid, chan_low, chan_mid, chan_high, alpha, last_pixel,
      input ready
   );
   modport sink (
      input valid, chan_low, chan_mid, chan_high, alpha, last_pixel,
      output ready
   );
endinterface

interface dxt1_csr_if;
   logic valid;
   logic ready;
   logic [dxt1_pkg::CSR_INDEX_W-1:0] index;
   logic [dxt1_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/dxt1_front.sv
// Front end: accepts a block word, expands the endpoints and builds the four-entry palette.
// Depends on dxt1_pkg and dxt1_req_if.
module dxt1_front (
   input logic clock,
   input logic reset,
   dxt1_req_if.sink req_port,
   input logic [1:0] cols_m1,
   input logic [1:0] rows_m1,
   output logic push_valid,
   input logic push_ready,
   output dxt1_pkg::block_type push_block
);
   import dxt1_pkg::*;

   logic s1_valid_ff, s1_valid_in;
   color_type a_ff, b_ff;
   logic [2:0][9:0] sum_2ab_ff, sum_a2b_ff;
   logic [2:0][8:0] sum_ab_ff;
   logic four_ff;
   logic [3:0][7:0] idx_ff;
   logic [1:0] cols_ff, rows_ff;
   color_type a_w, b_w, mid2_w, mid3_w;
   logic accept;

   assign req_port.ready = !s1_valid_ff || push_ready;
   assign accept = req_port.valid && req_port.ready;

   assign a_w[0] = {req_port.endpoint_zero[4:0], 3'd0};
   assign a_w[1] = {req_port.endpoint_zero[10:5], 2'd0};
   assign a_w[2] = {req_port.endpoint_zero[15:11], 3'd0};
   assign b_w[0] = {req_port.endpoint_one[4:0], 3'd0};
   assign b_w[1] = {req_port.endpoint_one[10:5], 2'd0};
   assign b_w[2] = {req_port.endpoint_one[15:11], 3'd0};

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (push_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_ff <= a_w;
         b_ff <= b_w;
         for (int k = 0; k < 3; k++) begin
            sum_2ab_ff[k] <= {1'b0, a_w[k], 1'b0} + {2'd0, b_w[k]};
            sum_a2b_ff[k] <= {2'd0, a_w[k]} + {1'b0, b_w[k], 1'b0};
            sum_ab_ff[k] <= {1'b0, a_w[k]} + {1'b0, b_w[k]};
         end
         four_ff <= req_port.endpoint_zero > req_port.endpoint_one;
         idx_ff <= {req_port.row_three_indices, req_port.row_two_indices,
                    req_port.row_one_indices, req_port.row_zero_indices};
         cols_ff <= cols_m1;
         rows_ff <= rows_m1;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (four_ff) begin
            mid2_w[k] = div3(sum_2ab_ff[k]);
            mid3_w[k] = div3(sum_a2b_ff[k]);
         end else begin
            mid2_w[k] = sum_ab_ff[k][8:1];
            mid3_w[k] = '0;
         end
      end
   end

   assign push_valid = s1_valid_ff;
   assign push_block.pal = {mid3_w, mid2_w, b_ff, a_ff};
   assign push_block.four_colour = four_ff;
   assign push_block.row_indices = idx_ff;
   assign push_block.cols_m1 = cols_ff;
   assign push_block.rows_m1 = rows_ff;

endmodule

// File: rtl/dxt1_queue.sv
// Short block queue between the front end and the pixel emitter.
// Depends on dxt1_pkg for the block type.
module dxt1_queue #(
   parameter int DEPTH = 2
) (
   input logic clock,
   input logic reset,
   input logic push_valid,
   output logic push_ready,
   input dxt1_pkg::block_type push_block,
   output logic pop_valid,
   input logic pop_ready,
   output dxt1_pkg::block_type pop_block
);
   import dxt1_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   block_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic push, pop;

   assign push_ready = count_ff != FULL_CNT;
   assign pop_valid = count_ff != '0;
   assign push = push_valid && push_ready;
   assign pop = pop_valid && pop_ready;
   assign pop_block = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_block;
      end
   end

endmodule

// File: rtl/dxt1_back.sv
// Back end: walks the clipped pixel grid of one block and drives the result register.
// Depends on dxt1_pkg and dxt1_rsp_if.
module dxt1_back (
   input logic clock,
   input logic reset,
   input logic blk_valid,
   output logic blk_pop,
   input dxt1_pkg::block_type blk,
   dxt1_rsp_if.source rsp_port
);
   import dxt1_pkg::*;

   logic [1:0] row_ff, col_ff;
   logic rsp_valid_ff, last_ff;
   color_type color_ff;
   logic [CHAN_W-1:0] alpha_ff;
   logic [1:0] idx;
   logic advance, step, row_end, blk_end;

   assign advance = !rsp_valid_ff || rsp_port.ready;
   assign step = advance && blk_valid;
   assign idx = blk.row_indices[row_ff][{col_ff, 1'b0} +: 2];
   assign row_end = col_ff == blk.cols_m1;
   assign blk_end = row_end && (row_ff == blk.rows_m1);
   assign blk_pop = step && blk_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         if (advance) begin
            rsp_valid_ff <= blk_valid;
         end
         if (step) begin
            if (row_end) begin
               col_ff <= '0;
               row_ff <= blk_end ? 2'd0 : row_ff + 2'd1;
            end else begin
               col_ff <= col_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         color_ff <= blk.pal[idx];
         alpha_ff <= (idx == IDX_TRANSPARENT && !blk.four_colour) ? ALPHA_CLEAR : ALPHA_OPAQUE;
         last_ff <= blk_end;
      end
   end

   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.chan_low = color_ff[0];
   assign rsp_port.chan_mid = color_ff[1];
   assign rsp_port.chan_high = color_ff[2];
   assign rsp_port.alpha = alpha_ff;
   assign rsp_port.last_pixel = last_ff;

endmodule

// File: rtl/dxt1_block_decoder_core.sv
// Top level of the DXT1 block decoder: register file, front end, block queue and pixel emitter.
// Depends on dxt1_pkg, the interfaces in dxt1_if, dxt1_front, dxt1_queue and dxt1_back.
//
// A block word on req_port carries two RGB565 endpoints and four row bytes of 2-bit indices.
// Each block yields valid_rows x valid_columns pixels on rsp_port in row-major order, one
// word per cycle while rsp_port is ready, with last_pixel set on the final one. The csr_port
// is always ready; index 0 writes valid_columns, index 1 writes valid_rows, other indexes
// are ignored. Writes apply to blocks accepted afterwards.
// A block passes the front-end register and the queue before its first pixel reaches the
// output register. Throughput is one pixel per cycle while rsp_port is ready, set by the
// back end's pixel walk. The front end and a queue of QUEUE_DEPTH blocks keep accepting while
// the back end emits. A stalled receiver holds the current pixel in the output register and
// the backlog fills the queue, then the front end, and only then drops req_port.ready.
// Reset empties the pipeline and sets both extents to four.
module dxt1_block_decoder_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input logic clock,
   input logic reset,
   dxt1_req_if.sink req_port,
   dxt1_rsp_if.source rsp_port,
   dxt1_csr_if.sink csr_port
);
   import dxt1_pkg::*;

   logic [1:0] cols_m1_ff, rows_m1_ff;
   logic push_valid, push_ready, pop_valid, pop_ready;
   block_type push_block, pop_block;

   assign csr_port.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_m1_ff <= 2'd3;
         rows_m1_ff <= 2'd3;
      end else if (csr_port.valid) begin
         unique case (csr_port.index)
            CSR_VALID_COLUMNS: cols_m1_ff <= extent_last(csr_port.data);
            CSR_VALID_ROWS: rows_m1_ff <= extent_last(csr_port.data);
            default: ;
         endcase
      end
   end

   dxt1_front u_front (
      .clock(clock),
      .reset(reset),
      .req_port(req_port),
      .cols_m1(cols_m1_ff),
      .rows_m1(rows_m1_ff),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_block(push_block)
   );

   dxt1_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock(clock),
      .reset(reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_block(push_block),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_block(pop_block)
   );

   dxt1_back u_back (
      .clock(clock),
      .reset(reset),
      .blk_valid(pop_valid),
      .blk_pop(pop_ready),
      .blk(pop_block),
      .rsp_port(rsp_port)
   );

endmodule

// File: rtl/dxt1_checker.sv
// Port-level checks of the DXT1 block decoder and the bind that attaches them to the top level.
// Depends on dxt1_block_decoder_core and the interfaces in dxt1_if.
module dxt1_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [7:0] chan_low,
   input logic [7:0] chan_mid,
   input logic [7:0] chan_high,
   input logic [7:0] alpha,
   input logic last_pixel
);

   logic [3:0] open_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_ff + 4'(req_valid && req_ready)
                    - 4'(rsp_valid && rsp_ready && last_pixel);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({chan_low, chan_mid, chan_high,
                                                      alpha, last_pixel}))
      else $error("stalled pixel word changed");

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("pixel word offered right after reset");

   a_last_owned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && last_pixel |-> open_ff != 4'd0)
      else $error("block end without an accepted block");

   a_alpha_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> alpha == 8'h00 || alpha == 8'hff)
      else $error("alpha is neither clear nor opaque");

   a_clear_black: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && alpha == 8'h00 |-> chan_low == 8'h00 && chan_mid == 8'h00
                                      && chan_high == 8'h00)
      else $error("transparent pixel is not black");

endmodule

bind dxt1_block_decoder_core dxt1_checker u_dxt1_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_port.valid),
   .req_ready(req_port.ready),
   .rsp_valid(rsp_port.valid),
   .rsp_ready(rsp_port.ready),
   .chan_low(rsp_port.chan_low),
   .chan_mid(rsp_port.chan_mid),
   .chan_high(rsp_port.chan_high),
   .alpha(rsp_port.alpha),
   .last_pixel(rsp_port.last_pixel)
);

// File: tb/testbench.sv
// Self-checking testbench for dxt1_block_decoder_core: DXT1 blocks in, RGBA pixel words out.
// Depends on dxt1_pkg and the channel interfaces in dxt1_if; a scoreboard class predicts pixels.
// Runs directed blocks, then random blocks under several extent settings, most with random stalls.
module testbench;
   import dxt1_pkg::*;

   typedef struct packed {
      logic [7:0] chan_low;
      logic [7:0] chan_mid;
      logic [7:0] chan_high;
      logic [7:0] alpha;
      logic last_pixel;
   } pixel_word_type;

   typedef struct packed {
      logic [15:0] endpoint_zero;
      logic [15:0] endpoint_one;
      logic [3:0][7:0] row_indices;
   } block_word_type;

   class pixel_scoreboard;
      pixel_word_type expected_pixels[$];
      int mismatches = 0;
      int blocks_seen = 0;
      int pixels_seen = 0;

      task report(input string what);
         mismatches++;
         $display("MISMATCH at %0t: %s", $realtime, what);
      endtask

      static function int extent_of(input logic [CSR_DATA_W-1:0] raw);
         if (raw == 0) begin
            return 1;
         end else if (raw > 4) begin
            return 4;
         end
         return int'(raw);
      endfunction

      task note_block(input block_word_type blk, input logic [CSR_DATA_W-1:0] cols_raw,
                      input logic [CSR_DATA_W-1:0] rows_raw);
         int pal[4][3];
         int alph[4];
         int cols;
         int rows;
         int a;
         int b;
         int idx;
         logic [15:0] ep[2];
         bit four_colour;
         pixel_word_type px;
         cols = extent_of(cols_raw);
         rows = extent_of(rows_raw);
         ep[0] = blk.endpoint_zero;
         ep[1] = blk.endpoint_one;
         four_colour = blk.endpoint_zero > blk.endpoint_one;
         for (int e = 0; e < 2; e++) begin
            pal[e][0] = int'({ep[e][4:0], 3'b000});
            pal[e][1] = int'({ep[e][10:5], 2'b00});
            pal[e][2] = int'({ep[e][15:11], 3'b000});
         end
         for (int k = 0; k < 3; k++) begin
            a = pal[0][k];
            b = pal[1][k];
            if (four_colour) begin
               pal[2][k] = (2 * a + b) / 3;
               pal[3][k] = (a + 2 * b) / 3;
            end else begin
               pal[2][k] = (a + b) / 2;
               pal[3][k] = 0;
            end
         end
         alph[0] = 255;
         alph[1] = 255;
         alph[2] = 255;
         alph[3] = four_colour ? 255 : 0;
         for (int r = 0; r < rows; r++) begin
            for (int c = 0; c < cols; c++) begin
               idx = int'(blk.row_indices[r][2*c +: 2]);
               px.chan_low = 8'(pal[idx][0]);
               px.chan_mid = 8'(pal[idx][1]);
               px.chan_high = 8'(pal[idx][2]);
               px.alpha = 8'(alph[idx]);
               px.last_pixel = (r == rows - 1) && (c == cols - 1);
               expected_pixels.push_back(px);
            end
         end
         blocks_seen++;
      endtask

      task check_pixel(input pixel_word_type got);
         pixel_word_type want;
         string diff;
         pixels_seen++;
         if (expected_pixels.size() == 0) begin
            report($sformatf("pixel word %h arrived with nothing expected", got));
            return;
         end
         want = expected_pixels.pop_front();
         diff = "";
         if (got.chan_low != want.chan_low) begin
            diff = {diff, $sformatf(" chan_low %h/%h", got.chan_low, want.chan_low)};
         end
         if (got.chan_mid != want.chan_mid) begin
            diff = {diff, $sformatf(" chan_mid %h/%h", got.chan_mid, want.chan_mid)};
         end
         if (got.chan_high != want.chan_high) begin
            diff = {diff, $sformatf(" chan_high %h/%h", got.chan_high, want.chan_high)};
         end
         if (got.alpha != want.alpha) begin
            diff = {diff, $sformatf(" alpha %h/%h", got.alpha, want.alpha)};
         end
         if (got.last_pixel != want.last_pixel) begin
            diff = {diff, $sformatf(" last_pixel %b/%b", got.last_pixel, want.last_pixel)};
         end
         if (diff != "") begin
            report({"pixel word", diff, " (got/expected)"});
         end
      endtask
   endclass

   logic clock;
   logic reset;

   dxt1_req_if req_bus ();
   dxt1_rsp_if rsp_bus ();
   dxt1_csr_if csr_bus ();

   dxt1_block_decoder_core u_top (
      .clock(clock),
      .reset(reset),
      .req_port(req_bus),
      .rsp_port(rsp_bus),
      .csr_port(csr_bus)
   );

   pixel_scoreboard board = new();

   logic [CSR_DATA_W-1:0] cur_cols;
   logic [CSR_DATA_W-1:0] cur_rows;
   int stall_odds;
   int gap_odds;
   int stall_left;
   int hold_left;
   int long_hold_request;
   int settings_used;
   pixel_word_type rx_word;

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("dxt1_block_decoder_core test failed");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
         hold_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            rx_word.chan_low = rsp_bus.chan_low;
            rx_word.chan_mid = rsp_bus.chan_mid;
            rx_word.chan_high = rsp_bus.chan_high;
            rx_word.alpha = rsp_bus.alpha;
            rx_word.last_pixel = rsp_bus.last_pixel;
            board.check_pixel(rx_word);
         end
         if (long_hold_request > 0) begin
            hold_left = long_hold_request;
            long_hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_odds != 0 && $urandom_range(0, 7) < stall_odds) begin
            stall_left = $urandom_range(0, 12);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic block_word_type make_block(input logic [15:0] e0, input logic [15:0] e1,
                                                 input logic [31:0] rows);
      block_word_type blk;
      blk.endpoint_zero = e0;
      blk.endpoint_one = e1;
      blk.row_indices = rows;
      return blk;
   endfunction

   function automatic block_word_type random_block();
      block_word_type blk;
      blk.endpoint_zero = 16'($urandom);
      blk.endpoint_one = 16'($urandom);
      case ($urandom_range(0, 9))
         0: begin
            blk.endpoint_one = blk.endpoint_zero;
         end
         1: begin
            blk.endpoint_zero = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
            blk.endpoint_one = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
         end
         2: begin
            blk.endpoint_one = blk.endpoint_zero - 16'd1;
         end
         default: begin
         end
      endcase
      blk.row_indices = $urandom;
      return blk;
   endfunction

   task automatic send_block(input block_word_type blk);
      req_bus.valid <= 1'b1;
      req_bus.endpoint_zero <= blk.endpoint_zero;
      req_bus.endpoint_one <= blk.endpoint_one;
      req_bus.row_zero_indices <= blk.row_indices[0];
      req_bus.row_one_indices <= blk.row_indices[1];
      req_bus.row_two_indices <= blk.row_indices[2];
      req_bus.row_three_indices <= blk.row_indices[3];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_block(blk, cur_cols, cur_rows);
   endtask

   task automatic pause_sender(input int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic maybe_gap();
      if (gap_odds != 0 && $urandom_range(0, 7) < gap_odds) begin
         pause_sender($urandom_range(1, 13));
      end
   endtask

   task automatic drain_pixels();
      req_bus.valid <= 1'b0;
      while (board.expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (index)
         CSR_VALID_COLUMNS: cur_cols = value;
         CSR_VALID_ROWS: cur_rows = value;
         default: begin
         end
      endcase
   endtask

   task automatic set_extents(input logic [CSR_DATA_W-1:0] cols, input logic [CSR_DATA_W-1:0] rows,
                              input logic [CSR_INDEX_W-1:0] stray_index);
      write_reg(CSR_VALID_COLUMNS, cols);
      write_reg(CSR_VALID_ROWS, rows);
      write_reg(stray_index, CSR_DATA_W'($urandom));
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   initial begin
      block_word_type directed[16];
      logic [CSR_DATA_W-1:0] phase_cols[10];
      logic [CSR_DATA_W-1:0] phase_rows[10];
      logic [CSR_INDEX_W-1:0] stray;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.endpoint_zero = '0;
      req_bus.endpoint_one = '0;
      req_bus.row_zero_indices = '0;
      req_bus.row_one_indices = '0;
      req_bus.row_two_indices = '0;
      req_bus.row_three_indices = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      rsp_bus.ready = 1'b0;
      cur_cols = 3'd4;
      cur_rows = 3'd4;
      stall_odds = 0;
      gap_odds = 0;
      long_hold_request = 0;
      settings_used = 1;
      phase_cols = '{3'd1, 3'd0, 3'd7, 3'd4, 3'd1, 3'd2, 3'd5, 3'd3, 3'd0, 3'd4};
      phase_rows = '{3'd1, 3'd0, 3'd7, 3'd1, 3'd4, 3'd3, 3'd6, 3'd2, 3'd0, 3'd4};
      directed[0] = make_block(16'hffff, 16'h0000, 32'hffaa5500);
      directed[1] = make_block(16'h0000, 16'hffff, 32'he4e4e4e4);
      directed[2] = make_block(16'h1234, 16'h1234, 32'h1b1b1b1b);
      directed[3] = make_block(16'hffff, 16'hffff, 32'he4e4e4e4);
      directed[4] = make_block(16'h0000, 16'h0000, 32'he4e4e4e4);
      directed[5] = make_block(16'h0001, 16'h0000, 32'he4e4e4e4);
      directed[6] = make_block(16'h0000, 16'h0001, 32'he4e4e4e4);
      directed[7] = make_block(16'hf800, 16'h07e0, 32'he41b4eb1);
      directed[8] = make_block(16'h07e0, 16'h001f, 32'he41b4eb1);
      directed[9] = make_block(16'h001f, 16'hf800, 32'he41b4eb1);
      directed[10] = make_block(16'h8000, 16'h7fff, 32'h9c63c936);
      directed[11] = make_block(16'hffff, 16'hfffe, 32'he4e4e4e4);
      directed[12] = make_block(16'h7bef, 16'h8410, 32'hffffffff);
      directed[13] = make_block(16'hffe0, 16'h001f, 32'h00000000);
      directed[14] = make_block(16'haaaa, 16'h5555, 32'h5a5aa5a5);
      directed[15] = make_block(16'h5555, 16'haaaa, 32'h0ff0f00f);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      stall_odds = 2;
      gap_odds = 2;
      foreach (directed[i]) begin
         send_block(directed[i]);
         maybe_gap();
      end
      drain_pixels();

      for (int phase = 0; phase < 10; phase++) begin
         if (phase == 8) begin
            phase_cols[phase] = CSR_DATA_W'($urandom);
            phase_rows[phase] = CSR_DATA_W'($urandom);
         end
         stray = (phase == 0) ? 4'hf : CSR_INDEX_W'($urandom_range(2, 15));
         set_extents(phase_cols[phase], phase_rows[phase], stray);
         stall_odds = $urandom_range(1, 4);
         gap_odds = $urandom_range(1, 4);
         if (phase == 2) begin
            gap_odds = 0;
            long_hold_request = 400;
         end
         if (phase == 4 || phase == 9) begin
            stall_odds = 0;
            gap_odds = 0;
         end
         for (int i = 0; i < 40; i++) begin
            send_block(random_block());
            if (phase == 5 && i == 20) begin
               drain_pixels();
            end else begin
               maybe_gap();
            end
         end
         drain_pixels();
      end

      repeat (20) @(posedge clock);
      if (board.expected_pixels.size() != 0) begin
         board.report($sformatf("%0d expected pixel words never arrived",
                                board.expected_pixels.size()));
      end
      $display("Decoded %0d blocks into %0d pixel words over %0d extent settings.",
               board.blocks_seen, board.pixels_seen, settings_used);
      $display("Included a long output stall, a mid-phase drain and %0d mismatches.",
               board.mismatches);
      if (board.mismatches == 0) begin
         $display("dxt1_block_decoder_core test passed");
      end else begin
         $display("dxt1_block_decoder_core test failed");
      end
      $finish;
   end
endmodule

// File: dxt1_block_decoder_core.f
rtl/dxt1_pkg.sv
rtl/dxt1_if.sv
rtl/dxt1_front.sv
rtl/dxt1_queue.sv
rtl/dxt1_back.sv
rtl/dxt1_block_decoder_core.sv
rtl/dxt1_checker.sv
tb/testbench.sv
